>>> hdl/dnsa_pkg.sv
// dnsa_pkg: shared constants for the dns a-record response parser
// no dependencies; used by the interfaces, the parser and its checker
package dnsa_pkg;

  // configuration port
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic        REG_QUERY_ID   = 1'b0;
  localparam logic        REG_LOCAL_PORT = 1'b1;
  localparam logic [15:0] QUERY_ID_RST   = 16'd0;
  localparam logic [15:0] LOCAL_PORT_RST = 16'd49152;

  // result codes
  typedef logic [1:0] outcome_t;
  localparam outcome_t OUT_FOUND     = 2'd0;
  localparam outcome_t OUT_IGNORED   = 2'd1;
  localparam outcome_t OUT_MALFORMED = 2'd2;
  localparam outcome_t OUT_NO_A      = 2'd3;

  // protocol constants
  localparam logic [15:0] SERVER_PORT  = 16'd53;
  localparam logic [7:0]  LABEL_MASK   = 8'hc0;
  localparam logic [7:0]  PTR_TAG      = 8'hc0;
  localparam logic [3:0]  HDR_ID_LO    = 4'd1;
  localparam logic [3:0]  HDR_FLAGS_LO = 4'd3;
  localparam logic [3:0]  HDR_QD_LO    = 4'd5;
  localparam logic [3:0]  HDR_AN_LO    = 4'd7;
  localparam logic [3:0]  HDR_LAST     = 4'd11;
  localparam logic [3:0]  Q_FIXED_LEN  = 4'd4;
  localparam logic [3:0]  FX_TYPE_HI   = 4'd0;
  localparam logic [3:0]  FX_TYPE_LO   = 4'd1;
  localparam logic [3:0]  FX_CLASS_HI  = 4'd2;
  localparam logic [3:0]  FX_CLASS_LO  = 4'd3;
  localparam logic [3:0]  FX_RDLEN_HI  = 4'd8;
  localparam logic [3:0]  FX_RDLEN_LO  = 4'd9;
  localparam logic [15:0] TYPE_A       = 16'd1;
  localparam logic [15:0] CLASS_IN     = 16'd1;
  localparam logic [15:0] A_RDLEN      = 16'd4;

endpackage

>>> hdl/dnsa_if.sv
// dnsa_if: valid/ready channels for payload bytes in and parse results out
// depends on dnsa_pkg
interface dnsa_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  payload_byte;
  logic        is_final_byte;
  logic [15:0] source_port;
  logic [15:0] destination_port;

  modport source (output valid, payload_byte, is_final_byte, source_port,
                  destination_port, input ready);
  modport sink (input valid, payload_byte, is_final_byte, source_port,
                destination_port, output ready);
endinterface

interface dnsa_out_if;
  import dnsa_pkg::*;
  logic        valid;
  logic        ready;
  outcome_t    outcome;
  logic [31:0] resolved_address;

  modport source (output valid, outcome, resolved_address, input ready);
  modport sink (input valid, outcome, resolved_address, output ready);
endinterface

>>> hdl/dns_response_a_record_parser.sv
// dns_response_a_record_parser: byte-serial dns response parser, first ipv4 a record
// depends on dnsa_pkg and the dnsa_in_if / dnsa_out_if channels
// result: registered, valid in the cycle after the word carrying is_final_byte is taken
// throughput: one byte per cycle; input stalls only while a result is held and out ready is low
// reset: synchronous active-low rst_n clears parse state and result valid, and loads the config registers' reset values
module dns_response_a_record_parser (
  input  logic                           clk,
  input  logic                           rst_n,
  dnsa_in_if.sink                        in_chan,
  dnsa_out_if.source                     out_chan,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [dnsa_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [dnsa_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [dnsa_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);
  import dnsa_pkg::*;

  // parse phases
  localparam logic [2:0] PH_HEADER  = 3'd0;
  localparam logic [2:0] PH_NAME    = 3'd1;
  localparam logic [2:0] PH_LABEL   = 3'd2;
  localparam logic [2:0] PH_POINTER = 3'd3;
  localparam logic [2:0] PH_FIXED   = 3'd4;
  localparam logic [2:0] PH_ADDRESS = 3'd5;
  localparam logic [2:0] PH_SKIP    = 3'd6;
  localparam logic [2:0] PH_SETTLED = 3'd7;

  // config registers
  logic [15:0] query_id_r;
  logic [15:0] local_port_r;

  // parse state
  logic [2:0]  phase_r,      phase_nxt;
  logic [3:0]  hdr_pos_r,    hdr_pos_nxt;
  logic [15:0] hdr_shift_r,  hdr_shift_nxt;
  logic [15:0] q_left_r,     q_left_nxt;
  logic [15:0] a_left_r,     a_left_nxt;
  logic [5:0]  lbl_left_r,   lbl_left_nxt;
  logic [3:0]  fix_idx_r,    fix_idx_nxt;
  logic [15:0] rec_type_r,   rec_type_nxt;
  logic [15:0] rec_class_r,  rec_class_nxt;
  logic [15:0] rdata_left_r, rdata_left_nxt;
  logic [31:0] addr_acc_r,   addr_acc_nxt;
  outcome_t    settled_r,    settled_nxt;

  // result register
  logic        out_valid_r;
  outcome_t    out_outcome_r, out_outcome_nxt;
  logic [31:0] out_addr_r,    out_addr_nxt;

  logic        in_fire;
  logic        cfg_write;
  logic        ports_ok;
  logic [7:0]  b;
  logic [15:0] shift_v;
  logic [5:0]  lbl_dec;
  logic [15:0] q_dec;
  logic [15:0] a_dec;
  logic [15:0] rdata_dec;
  logic [15:0] rdata_full;
  logic [3:0]  fix_inc;

  // a new word may enter whenever the result register is free or draining
  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign in_fire       = in_chan.valid && in_chan.ready;

  assign out_chan.valid            = out_valid_r;
  assign out_chan.outcome          = out_outcome_r;
  assign out_chan.resolved_address = out_addr_r;

  // apb: zero wait states, register index in paddr[2]
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == REG_LOCAL_PORT) ? {16'd0, local_port_r}
                                                  : {16'd0, query_id_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      query_id_r   <= QUERY_ID_RST;
      local_port_r <= LOCAL_PORT_RST;
    end else if (cfg_write) begin
      if (paddr[2] == REG_LOCAL_PORT) begin
        local_port_r <= pwdata[15:0];
      end else begin
        query_id_r <= pwdata[15:0];
      end
    end
  end

  // byte-level helpers
  assign b          = in_chan.payload_byte;
  assign ports_ok   = (in_chan.source_port == SERVER_PORT) &&
                      (in_chan.destination_port == local_port_r);
  assign shift_v    = {hdr_shift_r[7:0], b};
  assign lbl_dec    = (lbl_left_r != 6'd0) ? lbl_left_r - 6'd1 : lbl_left_r;
  assign q_dec      = q_left_r - 16'd1;
  assign a_dec      = (a_left_r != 16'd0) ? a_left_r - 16'd1 : a_left_r;
  assign rdata_dec  = (rdata_left_r != 16'd0) ? rdata_left_r - 16'd1 : rdata_left_r;
  assign rdata_full = rdata_left_r | {8'd0, b};
  assign fix_inc    = fix_idx_r + 4'd1;

  // next parse state for the byte on the input
  always_comb begin
    phase_nxt      = phase_r;
    hdr_pos_nxt    = hdr_pos_r;
    hdr_shift_nxt  = hdr_shift_r;
    q_left_nxt     = q_left_r;
    a_left_nxt     = a_left_r;
    lbl_left_nxt   = lbl_left_r;
    fix_idx_nxt    = fix_idx_r;
    rec_type_nxt   = rec_type_r;
    rec_class_nxt  = rec_class_r;
    rdata_left_nxt = rdata_left_r;
    addr_acc_nxt   = addr_acc_r;
    settled_nxt    = settled_r;

    if (!ports_ok) begin
      // wrong ports on any byte override everything seen so far
      phase_nxt   = PH_SETTLED;
      settled_nxt = OUT_IGNORED;
    end else begin
      unique case (phase_r)
        PH_HEADER: begin
          hdr_shift_nxt = shift_v;
          if (hdr_pos_r == HDR_ID_LO && shift_v != query_id_r) begin
            phase_nxt   = PH_SETTLED;
            settled_nxt = OUT_IGNORED;
          end else if (hdr_pos_r == HDR_FLAGS_LO && !shift_v[15]) begin
            // not a response
            phase_nxt   = PH_SETTLED;
            settled_nxt = OUT_IGNORED;
          end else begin
            if (hdr_pos_r == HDR_QD_LO) q_left_nxt = shift_v;
            if (hdr_pos_r == HDR_AN_LO) a_left_nxt = shift_v;
            if (hdr_pos_r >= HDR_LAST) begin
              hdr_pos_nxt = 4'd0;
              if (q_left_r != 16'd0 || a_left_r != 16'd0) begin
                phase_nxt   = PH_NAME;
                fix_idx_nxt = 4'd0;
              end else begin
                phase_nxt   = PH_SETTLED;
                settled_nxt = OUT_NO_A;
              end
            end else begin
              hdr_pos_nxt = hdr_pos_r + 4'd1;
            end
          end
        end

        PH_NAME: begin
          if (b == 8'd0) begin
            phase_nxt   = PH_FIXED;
            fix_idx_nxt = 4'd0;
          end else if ((b & LABEL_MASK) == PTR_TAG) begin
            phase_nxt = PH_POINTER;
          end else if ((b & LABEL_MASK) != 8'd0) begin
            // reserved label types
            phase_nxt   = PH_SETTLED;
            settled_nxt = OUT_MALFORMED;
          end else begin
            lbl_left_nxt = b[5:0];
            phase_nxt    = PH_LABEL;
          end
        end

        PH_LABEL: begin
          lbl_left_nxt = lbl_dec;
          if (lbl_dec == 6'd0) phase_nxt = PH_NAME;
        end

        PH_POINTER: begin
          phase_nxt   = PH_FIXED;
          fix_idx_nxt = 4'd0;
        end

        PH_FIXED: begin
          if (q_left_r != 16'd0) begin
            // question: qtype and qclass skipped
            fix_idx_nxt = fix_inc;
            if (fix_inc >= Q_FIXED_LEN) begin
              q_left_nxt = q_dec;
              if (q_dec != 16'd0 || a_left_r != 16'd0) begin
                phase_nxt   = PH_NAME;
                fix_idx_nxt = 4'd0;
              end else begin
                phase_nxt   = PH_SETTLED;
                settled_nxt = OUT_NO_A;
              end
            end
          end else begin
            case (fix_idx_r)
              FX_TYPE_HI:  rec_type_nxt   = {b, 8'd0};
              FX_TYPE_LO:  rec_type_nxt   = rec_type_r | {8'd0, b};
              FX_CLASS_HI: rec_class_nxt  = {b, 8'd0};
              FX_CLASS_LO: rec_class_nxt  = rec_class_r | {8'd0, b};
              FX_RDLEN_HI: rdata_left_nxt = {b, 8'd0};
              FX_RDLEN_LO: rdata_left_nxt = rdata_full;
              default: ;
            endcase
            if (fix_idx_r < FX_RDLEN_LO) begin
              fix_idx_nxt = fix_inc;
            end else begin
              fix_idx_nxt = 4'd0;
              if (rec_type_r == TYPE_A && rec_class_r == CLASS_IN &&
                  rdata_left_nxt == A_RDLEN) begin
                addr_acc_nxt = 32'd0;
                phase_nxt    = PH_ADDRESS;
              end else if (rdata_left_nxt == 16'd0) begin
                a_left_nxt = a_dec;
                if (a_dec != 16'd0) begin
                  phase_nxt = PH_NAME;
                end else begin
                  phase_nxt   = PH_SETTLED;
                  settled_nxt = OUT_NO_A;
                end
              end else begin
                phase_nxt = PH_SKIP;
              end
            end
          end
        end

        PH_ADDRESS: begin
          addr_acc_nxt   = {addr_acc_r[23:0], b};
          rdata_left_nxt = rdata_dec;
          if (rdata_dec == 16'd0) begin
            phase_nxt   = PH_SETTLED;
            settled_nxt = OUT_FOUND;
          end
        end

        PH_SKIP: begin
          rdata_left_nxt = rdata_dec;
          if (rdata_dec == 16'd0) begin
            a_left_nxt = a_dec;
            if (a_dec != 16'd0) begin
              phase_nxt   = PH_NAME;
              fix_idx_nxt = 4'd0;
            end else begin
              phase_nxt   = PH_SETTLED;
              settled_nxt = OUT_NO_A;
            end
          end
        end

        PH_SETTLED: ;

        default: ;
      endcase
    end
  end

  // result for a datagram ending on this byte
  always_comb begin
    if (phase_nxt == PH_SETTLED) begin
      out_outcome_nxt = settled_nxt;
    end else if (phase_nxt == PH_HEADER) begin
      out_outcome_nxt = OUT_IGNORED;   // short header
    end else begin
      out_outcome_nxt = OUT_MALFORMED; // ended inside a question or answer
    end
    out_addr_nxt = (out_outcome_nxt == OUT_FOUND) ? addr_acc_nxt : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (in_fire && in_chan.is_final_byte)) begin
      // reset and end of datagram both return to the header phase
      phase_r      <= PH_HEADER;
      hdr_pos_r    <= 4'd0;
      hdr_shift_r  <= 16'd0;
      q_left_r     <= 16'd0;
      a_left_r     <= 16'd0;
      lbl_left_r   <= 6'd0;
      fix_idx_r    <= 4'd0;
      rec_type_r   <= 16'd0;
      rec_class_r  <= 16'd0;
      rdata_left_r <= 16'd0;
      addr_acc_r   <= 32'd0;
      settled_r    <= OUT_FOUND;
    end else if (in_fire) begin
      phase_r      <= phase_nxt;
      hdr_pos_r    <= hdr_pos_nxt;
      hdr_shift_r  <= hdr_shift_nxt;
      q_left_r     <= q_left_nxt;
      a_left_r     <= a_left_nxt;
      lbl_left_r   <= lbl_left_nxt;
      fix_idx_r    <= fix_idx_nxt;
      rec_type_r   <= rec_type_nxt;
      rec_class_r  <= rec_class_nxt;
      rdata_left_r <= rdata_left_nxt;
      addr_acc_r   <= addr_acc_nxt;
      settled_r    <= settled_nxt;
    end
  end

  // output register: loads on the final byte, clears when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire && in_chan.is_final_byte) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_chan.is_final_byte) begin
      out_outcome_r <= out_outcome_nxt;
      out_addr_r    <= out_addr_nxt;
    end
  end

endmodule

>>> hdl/dnsa_checker.sv
// dnsa_assertions: port-level assertions for the dns a-record parser
// depends on dnsa_pkg; bound to dns_response_a_record_parser below
module dnsa_assertions (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                in_final,
  input logic                out_valid,
  input logic                out_ready,
  input dnsa_pkg::outcome_t  out_outcome,
  input logic [31:0]         out_addr,
  input logic                pready
);
  import dnsa_pkg::*;

  // a final byte always yields a result word next cycle
  a_result_after_final: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_final |=> out_valid)
    else $error("no result after final byte");

  // a result only appears after a final byte was taken
  a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready && in_final))
    else $error("result without final byte");

  // address is zero unless a record was found
  a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_outcome != OUT_FOUND |-> out_addr == 32'd0)
    else $error("address set without a found record");

  // a held result blocks input so it cannot be overwritten
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while result held");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready low");

endmodule

bind dns_response_a_record_parser dnsa_assertions u_dnsa_assertions (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_chan.valid),
  .in_ready    (in_chan.ready),
  .in_final    (in_chan.is_final_byte),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .out_outcome (out_chan.outcome),
  .out_addr    (out_chan.resolved_address),
  .pready      (pready)
);

>>> tb/dnsa_checker.sv
// dnsa_checker: watches the payload, result and register ports of the a-record parser,
// predicts every result word from its own copy of the parse state and compares
// depends on dnsa_pkg and the dnsa_in_if / dnsa_out_if interfaces
module dnsa_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  dnsa_in_if                              in_mon,
  dnsa_out_if                             out_mon,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [dnsa_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [dnsa_pkg::CFG_DATA_W-1:0] pwdata,
  input  logic [dnsa_pkg::CFG_DATA_W-1:0] prdata,
  input  logic                            pready,
  output int                              mismatches,
  output int                              pending_results
);
  timeunit 1ns;
  timeprecision 1ps;
  import dnsa_pkg::*;

  localparam logic [15:0] RESPONSE_BIT = 16'h8000;

  typedef enum logic [3:0] {
    ST_HEADER, ST_NAME, ST_LABEL, ST_POINTER, ST_FIXED, ST_ADDR, ST_SKIP, ST_DONE
  } walk_state_t;

  typedef struct packed {
    outcome_t    outcome;
    logic [31:0] address;
  } answer_t;

  logic [15:0] query_id;
  logic [15:0] local_port;

  walk_state_t walk;
  logic [3:0]  hdr_pos;
  logic [15:0] hdr_word;
  logic [15:0] qd_left;
  logic [15:0] an_left;
  logic [5:0]  lbl_left;
  logic [3:0]  fix_idx;
  logic [15:0] rr_type;
  logic [15:0] rr_class;
  logic [15:0] rd_left;
  logic [31:0] addr_acc;
  outcome_t    verdict;

  answer_t expected_answers[$];

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    if (mismatches < 100) begin
      $display("%0t mismatch: %s got %h want %h", $realtime, what, got, want);
    end
    mismatches++;
  endtask

  function automatic void clear_walk();
    walk     = ST_HEADER;
    hdr_pos  = '0;
    hdr_word = '0;
    qd_left  = '0;
    an_left  = '0;
    lbl_left = '0;
    fix_idx  = '0;
    rr_type  = '0;
    rr_class = '0;
    rd_left  = '0;
    addr_acc = '0;
    verdict  = OUT_FOUND;
  endfunction

  function automatic void settle_with(outcome_t code);
    walk    = ST_DONE;
    verdict = code;
  endfunction

  function automatic void start_name();
    walk    = ST_NAME;
    fix_idx = '0;
  endfunction

  function automatic void after_section();
    if (an_left != 0) start_name();
    else settle_with(OUT_NO_A);
  endfunction

  function automatic void next_record();
    if (an_left != 0) an_left--;
    after_section();
  endfunction

  function automatic void end_name();
    walk    = ST_FIXED;
    fix_idx = '0;
  endfunction

  function automatic void header_byte(logic [7:0] b);
    hdr_word = {hdr_word[7:0], b};
    case (hdr_pos)
      HDR_ID_LO: begin
        if (hdr_word != query_id) begin
          settle_with(OUT_IGNORED);
          return;
        end
      end
      HDR_FLAGS_LO: begin
        if ((hdr_word & RESPONSE_BIT) == 16'h0) begin
          settle_with(OUT_IGNORED);
          return;
        end
      end
      HDR_QD_LO: qd_left = hdr_word;
      HDR_AN_LO: an_left = hdr_word;
      default: ;
    endcase
    if (hdr_pos >= HDR_LAST) begin
      hdr_pos = '0;
      if (qd_left != 0) start_name();
      else after_section();
      return;
    end
    hdr_pos++;
  endfunction

  function automatic void fixed_byte(logic [7:0] b);
    if (qd_left != 0) begin
      fix_idx++;
      if (fix_idx >= Q_FIXED_LEN) begin
        qd_left--;
        if (qd_left != 0) start_name();
        else after_section();
      end
      return;
    end
    case (fix_idx)
      FX_TYPE_HI:  rr_type  = {b, 8'h00};
      FX_TYPE_LO:  rr_type  = rr_type | {8'h00, b};
      FX_CLASS_HI: rr_class = {b, 8'h00};
      FX_CLASS_LO: rr_class = rr_class | {8'h00, b};
      FX_RDLEN_HI: rd_left  = {b, 8'h00};
      FX_RDLEN_LO: rd_left  = rd_left | {8'h00, b};
      default: ;
    endcase
    if (fix_idx < FX_RDLEN_LO) begin
      fix_idx++;
      return;
    end
    fix_idx = '0;
    if (rr_type == TYPE_A && rr_class == CLASS_IN && rd_left == A_RDLEN) begin
      addr_acc = '0;
      walk     = ST_ADDR;
    end else if (rd_left == 0) begin
      next_record();
    end else begin
      walk = ST_SKIP;
    end
  endfunction

  function automatic void walk_byte(logic [7:0] b);
    case (walk)
      ST_HEADER: header_byte(b);
      ST_NAME: begin
        if (b == 8'h00) end_name();
        else if ((b & LABEL_MASK) == PTR_TAG) walk = ST_POINTER;
        else if ((b & LABEL_MASK) != 8'h00) settle_with(OUT_MALFORMED);
        else begin
          lbl_left = b[5:0];
          walk     = ST_LABEL;
        end
      end
      ST_LABEL: begin
        if (lbl_left != 0) lbl_left--;
        if (lbl_left == 0) walk = ST_NAME;
      end
      // second byte of a compression pointer closes the name
      ST_POINTER: end_name();
      ST_FIXED: fixed_byte(b);
      ST_ADDR: begin
        addr_acc = {addr_acc[23:0], b};
        if (rd_left != 0) rd_left--;
        if (rd_left == 0) settle_with(OUT_FOUND);
      end
      ST_SKIP: begin
        if (rd_left != 0) rd_left--;
        if (rd_left == 0) next_record();
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    answer_t     want;
    logic [15:0] reg_val;
    if (!rst_n) begin
      query_id   = QUERY_ID_RST;
      local_port = LOCAL_PORT_RST;
      clear_walk();
      expected_answers.delete();
    end else begin
      // register port: writes update the copy, reads are compared
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr[2] == REG_QUERY_ID) query_id = pwdata[15:0];
          else local_port = pwdata[15:0];
        end else begin
          reg_val = (paddr[2] == REG_QUERY_ID) ? query_id : local_port;
          if (prdata !== {16'h0, reg_val}) report("register read", prdata, {16'h0, reg_val});
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.source_port != SERVER_PORT || in_mon.destination_port != local_port) begin
          settle_with(OUT_IGNORED);
        end else begin
          walk_byte(in_mon.payload_byte);
        end
        if (in_mon.is_final_byte) begin
          if (walk == ST_DONE) want.outcome = verdict;
          else if (walk == ST_HEADER) want.outcome = OUT_IGNORED;
          else want.outcome = OUT_MALFORMED;
          want.address = (want.outcome == OUT_FOUND) ? addr_acc : 32'h0;
          expected_answers.push_back(want);
          clear_walk();
        end
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_answers.size() == 0) begin
          report("result word with nothing expected", {30'h0, out_mon.outcome}, 32'h0);
        end else begin
          want = expected_answers.pop_front();
          if (out_mon.outcome !== want.outcome) begin
            report("outcome", {30'h0, out_mon.outcome}, {30'h0, want.outcome});
          end
          if (out_mon.resolved_address !== want.address) begin
            report("resolved_address", out_mon.resolved_address, want.address);
          end
        end
      end
    end
    pending_results = expected_answers.size();
  end

endmodule

>>> tb/testbench.sv
// testbench: top level for the dns a-record parser, drives datagram bytes,
// result back-pressure and register writes, and gives the verdict
// depends on dnsa_pkg, the dnsa interfaces, the parser and dnsa_checker
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import dnsa_pkg::*;

  localparam int PHASES       = 6;
  localparam int PHASE_BYTES  = 270;   // random bytes per register setting
  localparam int IDLE_LIMIT   = 2000;  // cycles without any handshake
  localparam int DRAIN_CYCLES = 4;     // result lands in the cycle after the final byte is taken

  logic clk = 1'b0;
  logic rst_n;

  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  int mismatches;
  int pending_results;

  dnsa_in_if  in_chan ();
  dnsa_out_if out_chan ();

  dns_response_a_record_parser uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  dnsa_checker result_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (in_chan),
    .out_mon         (out_chan),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .mismatches      (mismatches),
    .pending_results (pending_results)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // result side: per result word draw a stall, counted only while a word
  // is waiting; now and then switch to a calm stretch with no stalls
  // ---------------------------------------------------------------------
  logic out_fire = 1'b0;
  int   sink_wait = 0;
  bit   sink_calm = 1'b0;

  always @(posedge clk) out_fire <= out_chan.valid && out_chan.ready;

  always @(negedge clk) begin
    if (out_fire) begin
      if ($urandom_range(0, 7) == 0) sink_calm = !sink_calm;
      sink_wait = sink_calm ? 0 : $urandom_range(0, 19);
    end
    if (rst_n && sink_wait == 0) begin
      out_chan.ready <= 1'b1;
    end else begin
      out_chan.ready <= 1'b0;
      if (sink_wait != 0 && out_chan.valid) sink_wait--;
    end
  end

  // ---------------------------------------------------------------------
  // watchdog: any handshake on any port restarts the count
  // ---------------------------------------------------------------------
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) ||
        (psel && penable && pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------
  // datagram assembly
  // ---------------------------------------------------------------------
  logic [7:0]  dgram[$];
  logic [15:0] cur_qid;
  logic [15:0] cur_port;
  bit          src_calm;

  function automatic void put16(logic [15:0] v);
    dgram.push_back(v[15:8]);
    dgram.push_back(v[7:0]);
  endfunction

  function automatic void put32(logic [31:0] v);
    put16(v[31:16]);
    put16(v[15:0]);
  endfunction

  // id, flags, qdcount, ancount, then random nscount / arcount
  function automatic void put_header(logic [15:0] id, logic [15:0] flags,
                                     logic [15:0] qd, logic [15:0] an);
    put16(id);
    put16(flags);
    put16(qd);
    put16(an);
    put32($urandom);
  endfunction

  // type, class, random ttl, rdlength
  function automatic void put_fixed(logic [15:0] rtype, logic [15:0] rclass, logic [15:0] rlen);
    put16(rtype);
    put16(rclass);
    put32($urandom);
    put16(rlen);
  endfunction

  // random name: bare pointer, labels then root, labels then pointer, or root only
  function automatic void put_rand_name();
    int form;
    int len;
    form = $urandom_range(0, 3);
    if (form == 1 || form == 2) begin
      repeat ($urandom_range(1, 3)) begin
        len = ($urandom_range(0, 30) == 0) ? 63 : $urandom_range(1, 6);
        dgram.push_back(8'(len));
        repeat (len) dgram.push_back(8'($urandom));
      end
    end
    if (form == 0 || form == 2) begin
      dgram.push_back(PTR_TAG | 8'($urandom_range(0, 63)));
      dgram.push_back(8'($urandom));
    end else begin
      dgram.push_back(8'h00);
    end
  endfunction

  // mostly well-formed responses with random content, some broken on purpose
  function automatic void build_random();
    int          qd;
    int          an;
    int          kind;
    int          rlen;
    logic [15:0] id;
    logic [15:0] flags;
    dgram.delete();
    qd    = $urandom_range(0, 2);
    an    = $urandom_range(0, 3);
    id    = ($urandom_range(0, 9) != 0) ? cur_qid : 16'($urandom);
    flags = ($urandom_range(0, 9) != 0) ? (16'h8000 | 16'($urandom)) : 16'($urandom);
    put_header(id, flags, 16'(qd), 16'(an));
    repeat (qd) begin
      put_rand_name();
      put32($urandom);
    end
    repeat (an) begin
      put_rand_name();
      kind = $urandom_range(0, 9);
      rlen = $urandom_range(0, 6);
      if (kind < 5) begin
        rlen = 4;
        put_fixed(TYPE_A, CLASS_IN, A_RDLEN);
      end else if (kind < 7) begin
        put_fixed(16'($urandom_range(2, 40)), CLASS_IN, 16'(rlen));
      end else if (kind == 7) begin
        rlen = 4;
        put_fixed(TYPE_A, 16'($urandom), A_RDLEN);
      end else if (kind == 8) begin
        put_fixed(TYPE_A, CLASS_IN, 16'(rlen));
      end else begin
        put_fixed(16'($urandom), 16'($urandom), 16'(rlen));
      end
      repeat (rlen) dgram.push_back(8'($urandom));
    end
    repeat ($urandom_range(0, 3)) dgram.push_back(8'($urandom));
    // damage: cut short, overwrite a byte, or blow up a section count
    kind = $urandom_range(0, 19);
    if (kind < 3) begin
      dgram = dgram[0:$urandom_range(0, dgram.size() - 1)];
    end else if (kind < 5) begin
      dgram[$urandom_range(0, dgram.size() - 1)] = 8'($urandom);
    end else if (kind == 5) begin
      dgram[$urandom_range(4, 7)] = 8'($urandom);
    end
  endfunction

  // ---------------------------------------------------------------------
  // drivers, all starting and ending at a falling edge
  // ---------------------------------------------------------------------
  task automatic send_word(logic [7:0] b, logic fin, logic [15:0] sp, logic [15:0] dp);
    int gap;
    gap = src_calm ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_chan.valid            <= 1'b1;
    in_chan.payload_byte     <= b;
    in_chan.is_final_byte    <= fin;
    in_chan.source_port      <= sp;
    in_chan.destination_port <= dp;
    do @(posedge clk); while (!in_chan.ready);
    @(negedge clk);
  endtask

  // whole datagram; word gi (if any) carries the odd ports gsp / gdp
  task automatic send_dgram(logic [15:0] sp, logic [15:0] dp, int gi,
                            logic [15:0] gsp, logic [15:0] gdp);
    src_calm = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < dgram.size(); i++) begin
      if (i == gi) send_word(dgram[i], i == dgram.size() - 1, gsp, gdp);
      else send_word(dgram[i], i == dgram.size() - 1, sp, dp);
    end
  endtask

  task automatic send_good();
    send_dgram(SERVER_PORT, cur_port, -1, 16'h0, 16'h0);
  endtask

  // setup phase, access phase, wait for pready, then return to idle
  task automatic apb_access(logic wr, logic idx, logic [CFG_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------
  initial begin
    int          sent;
    int          mode;
    int          gi;
    logic [15:0] sp;
    logic [15:0] dp;

    rst_n                    = 1'b0;
    in_chan.valid            = 1'b0;
    in_chan.payload_byte     = '0;
    in_chan.is_final_byte    = 1'b0;
    in_chan.source_port      = '0;
    in_chan.destination_port = '0;
    psel                     = 1'b0;
    penable                  = 1'b0;
    pwrite                   = 1'b0;
    paddr                    = '0;
    pwdata                   = '0;
    src_calm                 = 1'b0;

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int ph = 0; ph < PHASES; ph++) begin
      // register setting for this phase: extremes, defaults and random values
      case (ph)
        0: begin
          cur_qid  = 16'ha5c3;
          cur_port = LOCAL_PORT_RST;
        end
        1: begin
          cur_qid  = 16'h0000;
          cur_port = 16'h0000;
        end
        2: begin
          cur_qid  = 16'hffff;
          cur_port = 16'hffff;
        end
        5: begin
          cur_qid  = 16'($urandom);
          cur_port = SERVER_PORT;
        end
        default: begin
          cur_qid  = 16'($urandom);
          cur_port = 16'($urandom);
        end
      endcase
      // upper data bits are random and must be dropped by the block
      apb_access(1'b1, REG_QUERY_ID, {16'($urandom), cur_qid});
      apb_access(1'b1, REG_LOCAL_PORT, {16'($urandom), cur_port});
      apb_access(1'b0, REG_QUERY_ID, '0);
      apb_access(1'b0, REG_LOCAL_PORT, '0);

      if (ph == 0) begin
        // answer found after a plain label name, trailing bytes after the match
        dgram.delete();
        put_header(cur_qid, 16'h8180, 16'd0, 16'd1);
        dgram.push_back(8'd3);
        put16(16'h6162);
        dgram.push_back(8'h63);
        dgram.push_back(8'h00);
        put_fixed(TYPE_A, CLASS_IN, A_RDLEN);
        put32(32'hffff_ffff);
        put16(16'hdead);
        send_good();

        // one question, a record of another type, then an a record behind a pointer
        dgram.delete();
        put_header(cur_qid, 16'h8000, 16'd1, 16'd2);
        dgram.push_back(8'd1);
        dgram.push_back(8'h77);
        dgram.push_back(8'h00);
        put32(32'h0001_0001);
        put16(16'hc00c);
        put_fixed(16'd5, CLASS_IN, 16'd2);
        put16(16'h1234);
        put16(16'hff3f);
        put_fixed(TYPE_A, CLASS_IN, A_RDLEN);
        put32(32'h0000_0000);
        send_good();

        // same message, wrong source port throughout
        send_dgram(16'hffff, cur_port, -1, 16'h0, 16'h0);
        // same message, destination port wrong on the final word only
        gi = dgram.size() - 1;
        send_dgram(SERVER_PORT, cur_port, gi, SERVER_PORT, 16'h0000);

        // datagram ends inside the header
        dgram.delete();
        put16(cur_qid);
        put16(16'h8000);
        dgram.push_back(8'h00);
        send_good();

        // wrong transaction id
        dgram.delete();
        put_header(~cur_qid, 16'h8000, 16'd0, 16'd1);
        put16(16'hc00c);
        put_fixed(TYPE_A, CLASS_IN, A_RDLEN);
        put32(32'h0a00_0001);
        send_good();

        // response bit clear
        dgram.delete();
        put_header(cur_qid, 16'h7fff, 16'd0, 16'd1);
        put16(16'hc00c);
        put_fixed(TYPE_A, CLASS_IN, A_RDLEN);
        put32(32'h0a00_0002);
        send_good();

        // reserved label types 0x40 and 0x80
        dgram.delete();
        put_header(cur_qid, 16'h8000, 16'd1, 16'd0);
        dgram.push_back(8'h40);
        put16(16'h0102);
        send_good();
        dgram.delete();
        put_header(cur_qid, 16'h8000, 16'd1, 16'd0);
        dgram.push_back(8'hbf);
        send_good();

        // datagram ends inside a question label
        dgram.delete();
        put_header(cur_qid, 16'h8000, 16'd1, 16'd1);
        dgram.push_back(8'd5);
        put16(16'h6869);
        send_good();

        // no questions and no answers, then stray bytes
        dgram.delete();
        put_header(cur_qid, 16'h8000, 16'd0, 16'd0);
        put16(16'hffff);
        send_good();

        // the only answer is an a record with empty data
        dgram.delete();
        put_header(cur_qid, 16'h8000, 16'd0, 16'd1);
        dgram.push_back(8'h00);
        put_fixed(TYPE_A, CLASS_IN, 16'd0);
        send_good();

        // single word datagram
        dgram.delete();
        dgram.push_back(8'hff);
        send_good();
      end

      sent = 0;
      while (sent < PHASE_BYTES) begin
        build_random();
        mode = $urandom_range(0, 19);
        gi   = -1;
        sp   = SERVER_PORT;
        dp   = cur_port;
        if (mode == 0) sp = 16'($urandom);
        else if (mode == 1) dp = 16'($urandom);
        else if (mode == 2) gi = $urandom_range(0, dgram.size() - 1);
        send_dgram(sp, dp, gi, 16'($urandom), 16'($urandom));
        sent += dgram.size();
      end

      // idle the block before touching the registers again
      in_chan.valid <= 1'b0;
      while (pending_results != 0) @(negedge clk);
      repeat (DRAIN_CYCLES) @(negedge clk);
    end

    if (mismatches == 0 && pending_results == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/dnsa_pkg.sv
hdl/dnsa_if.sv
hdl/dns_response_a_record_parser.sv
hdl/dnsa_checker.sv
tb/dnsa_checker.sv
tb/testbench.sv
